// File: hw/rtl/ssrch_pkg.sv
// Shared constants and types for the substring search block.
// Depends on nothing; used by substring_search.
package ssrch_pkg;

  localparam int PAT_DEPTH = 64;
  localparam int TXT_DEPTH = 256;
  localparam int PAT_AW    = $clog2(PAT_DEPTH);
  localparam int TXT_AW    = $clog2(TXT_DEPTH);
  // Width for position sums that must not wrap: start + pattern length.
  localparam int SUM_W     = ((PAT_AW > TXT_AW) ? PAT_AW : TXT_AW) + 2;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CMP   = 4'b1000
  } state_t;

  typedef logic [PAT_AW-1:0] pat_idx_t;
  typedef logic [TXT_AW-1:0] txt_idx_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

// File: hw/rtl/substring_search.sv
// Substring search top level: pattern and text stores, load logic and the
// brute-force compare sequencer. Depends on ssrch_pkg.
//
//  channel  ports                                        transfer
//  input    start, busy, in_operation, in_data_byte,     start & !busy
//           in_last
//  result   out_valid, out_found                         out_valid (one cycle)
//
// A pattern byte or a text byte that is not the last one leaves busy low.
// The last text byte starts a search on one shared byte comparator: a length
// check (ST_CHECK), then a store read (ST_READ) and a compare (ST_CMP) per
// byte compare; busy is high during the search.
// The result strobe shows for one cycle and a new transfer may start in it.
// Reset is synchronous, active low, and resets the state, lengths and flags
// only (the pattern is marked closed); the receiver cannot stall the result.
module substring_search (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  output logic       out_found
);

  ssrch_pkg::state_t   state_r, state_nxt;

  logic [7:0]          pat_mem [ssrch_pkg::PAT_DEPTH];
  logic [7:0]          txt_mem [ssrch_pkg::TXT_DEPTH];

  ssrch_pkg::pat_idx_t pat_len_r, pat_len_nxt;
  logic                pat_closed_r, pat_closed_nxt;
  logic                pat_ended_r, pat_ended_nxt;
  ssrch_pkg::txt_idx_t txt_len_r, txt_len_nxt;
  logic                txt_closed_r, txt_closed_nxt;
  logic                txt_ended_r, txt_ended_nxt;

  ssrch_pkg::txt_idx_t pos_r, pos_nxt;
  ssrch_pkg::pat_idx_t k_r, k_nxt;
  logic [7:0]          pat_rd_r;
  logic [7:0]          txt_rd_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_match_r, out_match_nxt;

  logic                pat_we;
  ssrch_pkg::pat_idx_t pat_waddr;
  logic                txt_we;
  ssrch_pkg::txt_idx_t txt_waddr;

  logic                accept;
  ssrch_pkg::pat_idx_t pat_len_eff;
  logic                pat_ended_eff;
  ssrch_pkg::txt_idx_t txt_len_eff;
  logic                txt_ended_eff;
  ssrch_pkg::txt_idx_t txt_raddr;
  ssrch_pkg::sum_t     next_end;

  assign busy      = (state_r != ssrch_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_found = out_match_r;

  assign txt_raddr = ssrch_pkg::TXT_AW'(pos_r + ssrch_pkg::TXT_AW'(k_r));
  // End of the next window if the pattern moves on by one position.
  assign next_end  = ssrch_pkg::SUM_W'(pos_r) + ssrch_pkg::SUM_W'(1)
                   + ssrch_pkg::SUM_W'(pat_len_r);

  always_comb begin
    state_nxt      = state_r;
    pat_len_nxt    = pat_len_r;
    pat_closed_nxt = pat_closed_r;
    pat_ended_nxt  = pat_ended_r;
    txt_len_nxt    = txt_len_r;
    txt_closed_nxt = txt_closed_r;
    txt_ended_nxt  = txt_ended_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    out_valid_nxt  = 1'b0;
    out_match_nxt  = out_match_r;
    pat_we         = 1'b0;
    pat_waddr      = pat_len_r;
    txt_we         = 1'b0;
    txt_waddr      = txt_len_r;

    // A byte for a closed string restarts that string first.
    pat_len_eff    = pat_closed_r ? '0 : pat_len_r;
    pat_ended_eff  = pat_closed_r ? 1'b0 : pat_ended_r;
    txt_len_eff    = txt_closed_r ? '0 : txt_len_r;
    txt_ended_eff  = txt_closed_r ? 1'b0 : txt_ended_r;

    case (state_r)
      ssrch_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == ssrch_pkg::OP_PATTERN) begin
            pat_len_nxt    = pat_len_eff;
            pat_ended_nxt  = pat_ended_eff;
            pat_closed_nxt = in_last;
            if (!pat_ended_eff) begin
              if (in_data_byte == 8'd0) begin
                pat_ended_nxt = 1'b1;
              end else if (pat_len_eff !=
                           ssrch_pkg::PAT_AW'(ssrch_pkg::PAT_DEPTH - 1)) begin
                pat_we      = 1'b1;
                pat_waddr   = pat_len_eff;
                pat_len_nxt = pat_len_eff + 1'b1;
              end
            end
          end else begin
            txt_len_nxt    = txt_len_eff;
            txt_ended_nxt  = txt_ended_eff;
            txt_closed_nxt = in_last;
            if (!txt_ended_eff) begin
              if (in_data_byte == 8'd0) begin
                txt_ended_nxt = 1'b1;
              end else if (txt_len_eff !=
                           ssrch_pkg::TXT_AW'(ssrch_pkg::TXT_DEPTH - 1)) begin
                txt_we      = 1'b1;
                txt_waddr   = txt_len_eff;
                txt_len_nxt = txt_len_eff + 1'b1;
              end
            end
            if (in_last) begin
              state_nxt = ssrch_pkg::ST_CHECK;
            end
          end
        end
      end
      ssrch_pkg::ST_CHECK: begin
        if (pat_len_r == '0 ||
            ssrch_pkg::SUM_W'(pat_len_r) > ssrch_pkg::SUM_W'(txt_len_r)) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = 1'b0;
          state_nxt     = ssrch_pkg::ST_IDLE;
        end else begin
          pos_nxt   = '0;
          k_nxt     = '0;
          state_nxt = ssrch_pkg::ST_READ;
        end
      end
      ssrch_pkg::ST_READ: begin
        state_nxt = ssrch_pkg::ST_CMP;
      end
      ssrch_pkg::ST_CMP: begin
        if (txt_rd_r == pat_rd_r) begin
          if (k_r == pat_len_r - 1'b1) begin
            out_valid_nxt = 1'b1;
            out_match_nxt = 1'b1;
            state_nxt     = ssrch_pkg::ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ssrch_pkg::ST_READ;
          end
        end else if (next_end > ssrch_pkg::SUM_W'(txt_len_r)) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = 1'b0;
          state_nxt     = ssrch_pkg::ST_IDLE;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          k_nxt     = '0;
          state_nxt = ssrch_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = ssrch_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ssrch_pkg::ST_IDLE;
      pat_len_r    <= '0;
      pat_closed_r <= 1'b1;
      pat_ended_r  <= 1'b0;
      txt_len_r    <= '0;
      txt_closed_r <= 1'b0;
      txt_ended_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pat_len_r    <= pat_len_nxt;
      pat_closed_r <= pat_closed_nxt;
      pat_ended_r  <= pat_ended_nxt;
      txt_len_r    <= txt_len_nxt;
      txt_closed_r <= txt_closed_nxt;
      txt_ended_r  <= txt_ended_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    out_match_r <= out_match_nxt;
  end

  // Stores: one write port each, registered read at the compare position.
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= in_data_byte;
    end
    pat_rd_r <= pat_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (txt_we) begin
      txt_mem[txt_waddr] <= in_data_byte;
    end
    txt_rd_r <= txt_mem[txt_raddr];
  end

endmodule

// File: dv/tb_substring_search.sv
// Self-checking testbench for substring_search: drives pattern and text byte
// transfers and checks each match result against a behavioral scoreboard.
// Depends on ssrch_pkg and the substring_search RTL.
`timescale 1ns / 100ps

module tb_substring_search;

  localparam int unsigned ITEM_TARGET = 1850;

  // Tracks the pattern and text stores and queues the expected match flags.
  class match_scoreboard;
    logic [7:0] pat_mem [ssrch_pkg::PAT_DEPTH];
    logic [7:0] txt_mem [ssrch_pkg::TXT_DEPTH];
    int         pat_len;
    int         txt_len;
    bit         pat_closed;
    bit         pat_ended;
    bit         txt_closed;
    bit         txt_ended;
    bit         expected_matches [$];
    int         result_idx;

    function void clear();
      pat_len    = 0;
      pat_closed = 1'b1;
      pat_ended  = 1'b0;
      txt_len    = 0;
      txt_closed = 1'b0;
      txt_ended  = 1'b0;
      result_idx = 0;
      expected_matches.delete();
    endfunction

    function bit pattern_in_text();
      int pos;
      int k;
      bit hit;
      if (pat_len == 0 || pat_len > txt_len) return 1'b0;
      for (pos = 0; pos + pat_len <= txt_len; pos++) begin
        hit = 1'b1;
        for (k = 0; k < pat_len; k++) begin
          if (txt_mem[pos + k] != pat_mem[k]) hit = 1'b0;
        end
        if (hit) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Returns 1 when the transfer changed state, i.e. was not simply ignored.
    function bit note_transfer(logic op, logic [7:0] data, logic is_last);
      bit counted;
      counted = is_last;
      if (op == ssrch_pkg::OP_PATTERN) begin
        if (pat_closed) begin
          pat_len    = 0;
          pat_ended  = 1'b0;
          pat_closed = 1'b0;
        end
        if (!pat_ended) begin
          if (data == 8'h00) begin
            pat_ended = 1'b1;
            counted   = 1'b1;
          end else if (pat_len < ssrch_pkg::PAT_DEPTH - 1) begin
            pat_mem[pat_len] = data;
            pat_len++;
            counted = 1'b1;
          end
        end
        if (is_last) pat_closed = 1'b1;
      end else begin
        if (txt_closed) begin
          txt_len    = 0;
          txt_ended  = 1'b0;
          txt_closed = 1'b0;
        end
        if (!txt_ended) begin
          if (data == 8'h00) begin
            txt_ended = 1'b1;
            counted   = 1'b1;
          end else if (txt_len < ssrch_pkg::TXT_DEPTH - 1) begin
            txt_mem[txt_len] = data;
            txt_len++;
            counted = 1'b1;
          end
        end
        if (is_last) begin
          txt_closed = 1'b1;
          expected_matches.push_back(pattern_in_text());
        end
      end
      return counted;
    endfunction

    function bit check_result(logic got, output string msg);
      bit want;
      msg = "";
      if (expected_matches.size() == 0) begin
        msg = $sformatf("result with no search pending, found=%b", got);
        return 1'b0;
      end
      want = expected_matches.pop_front();
      result_idx++;
      if (got !== want) begin
        msg = $sformatf("search %0d: found=%b, expected %b", result_idx, got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_operation = ssrch_pkg::OP_PATTERN;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_found;

  match_scoreboard sb;
  int              error_count = 0;
  int unsigned     loaded;
  bit              steady;
  bit              want_long_pattern = 1'b1;
  bit              want_long_text = 1'b1;
  logic [7:0]      pat_copy [$];
  logic [7:0]      str_buf [$];
  string           result_msg;

  substring_search dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_found    (out_found)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_error(input string what);
    error_count++;
    $display("[%0t] ERROR: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (!sb.check_result(out_found, result_msg)) report_error(result_msg);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic [7:0] pick_char(bit narrow);
    if (narrow) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_item(input logic op, input logic [7:0] data, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      // Junk on the payload while start is low must be ignored.
      start        <= 1'b0;
      in_operation <= 1'($urandom_range(0, 1));
      in_data_byte <= 8'($urandom_range(0, 255));
      in_last      <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    in_last      <= is_last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (sb.note_transfer(op, data, is_last)) loaded++;
  endtask

  task automatic send_string(input logic op, input bit close);
    int i;
    for (i = 0; i < str_buf.size(); i++) begin
      send_item(op, str_buf[i], close && (i == str_buf.size() - 1));
    end
  endtask

  task automatic run_directed();
    // Text before any pattern: the pattern is empty.
    send_item(ssrch_pkg::OP_TEXT, 8'h41, 1'b1);
    send_item(ssrch_pkg::OP_PATTERN, 8'hFF, 1'b1);
    send_item(ssrch_pkg::OP_TEXT, 8'hFF, 1'b1);
    // A pattern made of only a terminator is empty and never matches.
    send_item(ssrch_pkg::OP_PATTERN, 8'h00, 1'b1);
    send_item(ssrch_pkg::OP_TEXT, 8'h01, 1'b1);
    send_item(ssrch_pkg::OP_PATTERN, 8'hAA, 1'b0);
    send_item(ssrch_pkg::OP_PATTERN, 8'h55, 1'b1);
    // Pattern longer than the text.
    send_item(ssrch_pkg::OP_TEXT, 8'hAA, 1'b1);
    send_item(ssrch_pkg::OP_TEXT, 8'h01, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'hAA, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'h55, 1'b1);
    // The search runs with a pattern that is still open, then it grows.
    send_item(ssrch_pkg::OP_PATTERN, 8'h80, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'h80, 1'b1);
    send_item(ssrch_pkg::OP_PATTERN, 8'h7F, 1'b1);
    // A zero ends the text; the byte after it is dropped.
    send_item(ssrch_pkg::OP_TEXT, 8'h80, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'h00, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'h7F, 1'b1);
    send_item(ssrch_pkg::OP_TEXT, 8'h00, 1'b1);
    send_item(ssrch_pkg::OP_TEXT, 8'h80, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'h7F, 1'b1);
    send_item(ssrch_pkg::OP_PATTERN, 8'h01, 1'b0);
    send_item(ssrch_pkg::OP_PATTERN, 8'h00, 1'b0);
    send_item(ssrch_pkg::OP_PATTERN, 8'h02, 1'b1);
    send_item(ssrch_pkg::OP_TEXT, 8'h02, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'h01, 1'b1);
    send_item(ssrch_pkg::OP_TEXT, 8'hFE, 1'b0);
    send_item(ssrch_pkg::OP_TEXT, 8'h02, 1'b1);
  endtask

  task automatic load_random_pattern();
    int i;
    int len;
    int roll;
    bit narrow;
    narrow = ($urandom_range(0, 3) != 0);
    if (want_long_pattern) begin
      len = 70;
      want_long_pattern = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(58, 72);
    end else begin
      len = $urandom_range(1, 6);
    end
    str_buf.delete();
    for (i = 0; i < len; i++) str_buf.push_back(pick_char(narrow));
    pat_copy = str_buf;
    roll = $urandom_range(0, 9);
    if (roll == 0) str_buf.insert($urandom_range(0, str_buf.size()), 8'h00);
    // Sometimes the pattern is left open so the next search uses it as is.
    send_string(ssrch_pkg::OP_PATTERN, roll != 1);
  endtask

  task automatic load_random_text();
    int i;
    int len;
    int pos;
    bit narrow;
    narrow = ($urandom_range(0, 3) != 0);
    if (want_long_text) begin
      len = 270;
      want_long_text = 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      len = $urandom_range(240, 270);
    end else begin
      len = $urandom_range(0, 40);
    end
    str_buf.delete();
    for (i = 0; i < len; i++) str_buf.push_back(pick_char(narrow));
    if ($urandom_range(0, 1) == 1 && pat_copy.size() > 0 && pat_copy.size() <= len) begin
      pos = $urandom_range(0, len - pat_copy.size());
      for (i = 0; i < pat_copy.size(); i++) str_buf[pos + i] = pat_copy[i];
    end
    if ($urandom_range(0, 11) == 0) str_buf.insert($urandom_range(0, str_buf.size()), 8'h00);
    if (str_buf.size() == 0) str_buf.push_back(8'h00);
    send_string(ssrch_pkg::OP_TEXT, 1'b1);
  endtask

  // Stray transfers: broken sequences of either kind, terminators, random last flags.
  task automatic send_noise();
    int n;
    logic op;
    logic [7:0] data;
    logic is_last;
    n = $urandom_range(1, 6);
    repeat (n) begin
      op      = 1'($urandom_range(0, 1));
      data    = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      is_last = ($urandom_range(0, 3) == 0);
      send_item(op, data, is_last);
    end
  endtask

  initial begin
    int roll;
    sb = new();
    sb.clear();
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    loaded = 0;
    while (loaded < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        load_random_pattern();
      end else if (roll < 85) begin
        load_random_text();
      end else begin
        send_noise();
      end
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Far beyond the slowest legal run, long searches included.
  initial begin
    #2_000_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ssrch_pkg.sv
hw/rtl/substring_search.sv
dv/tb_substring_search.sv
